@@ rtl/ttps_pkg.sv @@
// ttps_pkg: shared types and constants for the transposition table probe store
// slot entry layout, bound kinds, transaction payload layout
// no dependencies
`default_nettype none

package ttps_pkg;

	localparam int INDEX_BITS = 16;
	localparam int SLOT_COUNT = 1 << INDEX_BITS;
	localparam int KEY_W      = 64;
	localparam int TAG_W      = KEY_W - INDEX_BITS;
	localparam int DEPTH_W    = 4;
	localparam int SCORE_W    = 32;
	localparam int KIND_W     = 2;

	localparam int IN_FIELDS_W  = KEY_W + DEPTH_W + SCORE_W + KIND_W + 2 * SCORE_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + SCORE_W + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic MODE_PROBE = 1'b0;
	localparam logic MODE_STORE = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_UPPER = 2'd0,
		KIND_LOWER = 2'd1,
		KIND_EXACT = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [DEPTH_W-1:0] depth;
		logic [SCORE_W-1:0] score;
		kind_t              kind;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic               mode;
		logic [KEY_W-1:0]   key;
		logic [DEPTH_W-1:0] depth;
		logic [SCORE_W-1:0] score;
		kind_t              kind;
		logic [SCORE_W-1:0] alpha;
		logic [SCORE_W-1:0] beta;
	} item_t;

	typedef struct packed {
		logic               found;
		logic [SCORE_W-1:0] value;
		logic               written;
	} result_t;

	localparam entry_t EMPTY_ENTRY = '{tag: '0, depth: '0, score: '0, kind: KIND_EMPTY};

endpackage

`default_nettype wire

@@ rtl/ttps_ram.sv @@
// ttps_ram: generic single-port-write, single-port-read synchronous ram
// read data registered, old data on same-address write
// no dependencies
`default_nettype none

module ttps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/ttps_eval.sv @@
// ttps_eval: probe hit test, bound window check and depth-preferred replace decision
// uses ttps_pkg
`default_nettype none

module ttps_eval (
	input  wire ttps_pkg::item_t   item,
	input  wire ttps_pkg::entry_t  entry,
	output ttps_pkg::result_t      res,
	output logic                   wr_en,
	output ttps_pkg::entry_t       wr_entry
);
	import ttps_pkg::*;

	logic match;
	logic replace;
	logic le_alpha;
	logic ge_beta;

	always_comb begin
		match    = (entry.kind != KIND_EMPTY) && (entry.tag == item.key[KEY_W-1:INDEX_BITS])
			&& (entry.depth >= item.depth);
		replace  = (item.kind != KIND_EMPTY)
			&& ((entry.kind == KIND_EMPTY) || (entry.depth < item.depth));
		le_alpha = $signed(entry.score) <= $signed(item.alpha);
		ge_beta  = $signed(entry.score) >= $signed(item.beta);

		res = '0;
		wr_en = 1'b0;
		wr_entry.tag   = item.key[KEY_W-1:INDEX_BITS];
		wr_entry.depth = item.depth;
		wr_entry.score = item.score;
		wr_entry.kind  = item.kind;

		if (item.mode == MODE_STORE) begin
			wr_en = replace;
			res.written = replace;
		end else if (match) begin
			case (entry.kind)
				KIND_EXACT: begin
					res.found = 1'b1;
					res.value = entry.score;
				end
				KIND_UPPER: begin
					if (le_alpha) begin
						res.found = 1'b1;
						res.value = item.alpha;
					end
				end
				KIND_LOWER: begin
					if (ge_beta) begin
						res.found = 1'b1;
						res.value = item.beta;
					end
				end
				default: begin
					res.found = 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/transposition_table_probe_store.sv @@
// transposition_table_probe_store: direct-mapped depth-preferred transposition table
// uses ttps_pkg, ttps_ram, ttps_eval
//
// channel   dir  fields
// s_axis    in   tuser: mode; tdata: key, depth, score, bound_kind, alpha, beta
// m_axis    out  tdata: found, value, written
//
// one transaction per cycle sustained while m_axis is ready; result registered after s1
// the slot entry lives in one ram; read at accept, modify and write back when s1 advances
// a written store to the same slot as the next probe or store is forwarded from a register
// after reset a clearing pass marks all 2^INDEX_BITS slots empty with s_axis_tready low
// m_axis stalls hold the result register and then the s1 stage, which drops s_axis_tready
`default_nettype none

module transposition_table_probe_store (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// key, depth, score, bound_kind, alpha, beta, zero pad
	input  wire logic [ttps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// mode
	input  wire logic                               s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// found, value, written, zero pad
	output logic      [ttps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import ttps_pkg::*;

	item_t                  in_item;
	logic                   accept;
	logic                   adv_s1;
	logic                   valid_s1_q;
	item_t                  item_s1;
	logic                   fwd_s1;
	entry_t                 fwd_entry_s1;
	logic                   clr_busy_q;
	logic [INDEX_BITS-1:0]  clr_idx_q;
	logic                   ram_we;
	logic [INDEX_BITS-1:0]  ram_waddr;
	entry_t                 ram_wdata;
	logic [ENTRY_W-1:0]     ram_rdata;
	entry_t                 cur_entry;
	result_t                res;
	logic                   ev_wr_en;
	entry_t                 ev_wr_entry;
	logic                   pipe_wr;
	logic                   out_valid_q;
	result_t                out_res_q;

	always_comb begin
		in_item.mode  = s_axis_tuser;
		in_item.key   = s_axis_tdata[63:0];
		in_item.depth = s_axis_tdata[67:64];
		in_item.score = s_axis_tdata[99:68];
		in_item.kind  = kind_t'(s_axis_tdata[101:100]);
		in_item.alpha = s_axis_tdata[133:102];
		in_item.beta  = s_axis_tdata[165:134];
	end

	assign adv_s1        = valid_s1_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clr_busy_q && (!valid_s1_q || adv_s1);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pipe_wr       = adv_s1 && ev_wr_en;
	assign cur_entry     = fwd_s1 ? fwd_entry_s1 : entry_t'(ram_rdata);

	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = EMPTY_ENTRY;
		end else begin
			ram_we    = pipe_wr;
			ram_waddr = item_s1.key[INDEX_BITS-1:0];
			ram_wdata = ev_wr_entry;
		end
	end

	ttps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (in_item.key[INDEX_BITS-1:0]),
		.rdata (ram_rdata)
	);

	ttps_eval u_eval (
		.item     (item_s1),
		.entry    (cur_entry),
		.res      (res),
		.wr_en    (ev_wr_en),
		.wr_entry (ev_wr_entry)
	);

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (&clr_idx_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// s1 stage and forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else if (accept) begin
			valid_s1_q <= 1'b1;
			fwd_s1     <= pipe_wr
				&& (item_s1.key[INDEX_BITS-1:0] == in_item.key[INDEX_BITS-1:0]);
		end else if (adv_s1) begin
			valid_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1      <= in_item;
			fwd_entry_s1 <= ev_wr_entry;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
		out_res_q.written, out_res_q.value, out_res_q.found};

	// checks
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !clr_busy_q)
		else $error("transaction accepted during clearing pass");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1_q)
		else $error("accepted transaction missing from s1");

	a_write_only_store: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !clr_busy_q) |-> (adv_s1 && item_s1.mode == MODE_STORE))
		else $error("table write without an advancing store");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(out_res_q.found && out_res_q.written))
		else $error("result both found and written");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !out_res_q.found) |-> (out_res_q.value == '0))
		else $error("nonzero value without a hit");

endmodule

`default_nettype wire

@@ test/transposition_table_probe_store_tb.sv @@
`timescale 1ns / 100ps
// transposition_table_probe_store_tb: self-checking bench for the transposition table
// sends probe and store transactions, predicts each result and checks it field by field
// depends on ttps_pkg and transposition_table_probe_store
`default_nettype none

module transposition_table_probe_store_tb;
	import ttps_pkg::*;

	localparam int STALL_LIMIT = 200000;
	localparam int POOL_SLOTS  = 8;
	localparam int POOL_WAYS   = 4;
	localparam int POOL_SIZE   = POOL_SLOTS * POOL_WAYS;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int mismatches = 0;
	int stall_cycles = 0;

	result_t            expected_results[$];
	logic [KEY_W-1:0]   tt_key   [SLOT_COUNT];
	logic [DEPTH_W-1:0] tt_depth [SLOT_COUNT];
	logic [SCORE_W-1:0] tt_score [SLOT_COUNT];
	kind_t              tt_kind  [SLOT_COUNT];
	logic [KEY_W-1:0]   key_pool [POOL_SIZE];

	transposition_table_probe_store dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic result_t predict_table_access(input item_t it);
		result_t            r;
		logic [INDEX_BITS-1:0] idx;
		r = '0;
		idx = it.key[INDEX_BITS-1:0];
		if (it.mode == MODE_STORE) begin
			if (it.kind != KIND_EMPTY &&
					(tt_kind[idx] == KIND_EMPTY || tt_depth[idx] < it.depth)) begin
				tt_key[idx] = it.key;
				tt_depth[idx] = it.depth;
				tt_score[idx] = it.score;
				tt_kind[idx] = it.kind;
				r.written = 1'b1;
			end
		end else if (tt_kind[idx] != KIND_EMPTY && tt_key[idx] == it.key &&
				tt_depth[idx] >= it.depth) begin
			case (tt_kind[idx])
				KIND_EXACT: begin
					r.found = 1'b1;
					r.value = tt_score[idx];
				end
				KIND_UPPER: begin
					if ($signed(tt_score[idx]) <= $signed(it.alpha)) begin
						r.found = 1'b1;
						r.value = it.alpha;
					end
				end
				KIND_LOWER: begin
					if ($signed(tt_score[idx]) >= $signed(it.beta)) begin
						r.found = 1'b1;
						r.value = it.beta;
					end
				end
				default: begin
				end
			endcase
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: expected found=%0b value=%h written=%0b, got found=%0b value=%h written=%0b",
				what, want.found, want.value, want.written, got.found, got.value, got.written);
		end
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.found = m_axis_tdata[0];
			got.value = m_axis_tdata[SCORE_W:1];
			got.written = m_axis_tdata[SCORE_W+1];
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected transaction", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (got.found !== want.found || got.value !== want.value ||
						got.written !== want.written) begin
					note_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic reset_dut();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			tt_kind[i] = KIND_EMPTY;
		end
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	endtask

	task automatic send_item(input logic mode, input logic [KEY_W-1:0] key,
			input logic [DEPTH_W-1:0] depth, input logic [SCORE_W-1:0] score,
			input kind_t kind, input logic [SCORE_W-1:0] alpha,
			input logic [SCORE_W-1:0] beta);
		item_t it;
		it.mode = mode;
		it.key = key;
		it.depth = depth;
		it.score = score;
		it.kind = kind;
		it.alpha = alpha;
		it.beta = beta;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.mode;
		s_axis_tdata <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, it.beta, it.alpha, it.kind,
			it.score, it.depth, it.key};
		do @(posedge clk); while (!s_axis_tready);
		expected_results.insert(expected_results.size(), predict_table_access(it));
	endtask

	task automatic test_empty_probe_and_ignored_store();
		send_item(MODE_PROBE, '1, 4'd0, 32'd0, KIND_UPPER, 32'h8000_0000, 32'h7fff_ffff);
		send_item(MODE_STORE, '1, 4'd15, 32'h7fff_ffff, KIND_EMPTY, 32'd0, 32'd0);
		send_item(MODE_PROBE, '1, 4'd0, 32'd0, KIND_EXACT, 32'h8000_0000, 32'h7fff_ffff);
		send_item(MODE_STORE, 64'd0, 4'd0, 32'h7fff_ffff, KIND_EXACT, '1, '1);
		send_item(MODE_PROBE, 64'd0, 4'd0, '1, KIND_EMPTY, 32'd0, 32'd0);
		send_item(MODE_PROBE, 64'h1_0000, 4'd0, 32'd0, KIND_LOWER, 32'd0, 32'd0);
	endtask

	task automatic test_depth_replacement();
		send_item(MODE_STORE, '1, 4'd0, 32'h8000_0000, KIND_EXACT, 32'd0, 32'd0);
		send_item(MODE_STORE, '1, 4'd0, 32'd5, KIND_EXACT, 32'd0, 32'd0);
		send_item(MODE_PROBE, '1, 4'd0, 32'd0, KIND_UPPER, 32'd0, 32'd0);
		send_item(MODE_STORE, 64'hffff, 4'd15, 32'h8000_0000, KIND_UPPER, 32'd0, 32'd0);
		send_item(MODE_PROBE, '1, 4'd0, 32'd0, KIND_UPPER, 32'd0, 32'd0);
		send_item(MODE_PROBE, 64'hffff, 4'd15, 32'd0, KIND_UPPER, 32'h8000_0000, 32'd0);
		send_item(MODE_STORE, 64'hffff, 4'd15, 32'd9, KIND_EXACT, 32'd0, 32'd0);
	endtask

	task automatic test_bound_windows();
		send_item(MODE_STORE, 64'd5, 4'd3, 32'd0, KIND_UPPER, 32'd0, 32'd0);
		send_item(MODE_PROBE, 64'd5, 4'd3, 32'd0, KIND_UPPER, '1, 32'd0);
		send_item(MODE_PROBE, 64'd5, 4'd3, 32'd0, KIND_UPPER, 32'd0, 32'd0);
		send_item(MODE_PROBE, 64'd5, 4'd0, 32'd0, KIND_UPPER, 32'h7fff_ffff, 32'd0);
		send_item(MODE_PROBE, 64'd5, 4'd4, 32'd0, KIND_UPPER, 32'h7fff_ffff, 32'd0);
		send_item(MODE_STORE, 64'd6, 4'd2, 32'd0, KIND_LOWER, 32'd0, 32'd0);
		send_item(MODE_PROBE, 64'd6, 4'd2, 32'd0, KIND_LOWER, 32'd0, 32'd1);
		send_item(MODE_PROBE, 64'd6, 4'd1, 32'd0, KIND_LOWER, 32'd0, 32'd0);
		send_item(MODE_PROBE, 64'd6, 4'd2, 32'd0, KIND_LOWER, 32'd0, 32'h8000_0000);
		send_item(MODE_STORE, 64'd7, 4'd1, '1, KIND_EXACT, 32'd0, 32'd0);
		send_item(MODE_PROBE, 64'd7, 4'd1, 32'd0, KIND_EXACT, 32'd0, 32'd0);
		send_item(MODE_STORE, 64'd7, 4'd2, 32'd3, KIND_LOWER, 32'd0, 32'd0);
	endtask

	task automatic test_random_traffic(input int count);
		logic [KEY_W-1:0]      key;
		logic [INDEX_BITS-1:0] idx;
		logic [SCORE_W-1:0]    near;
		logic [SCORE_W-1:0]    lo;
		logic [SCORE_W-1:0]    hi;
		logic [DEPTH_W-1:0]    d;
		logic [SCORE_W-1:0]    sc;
		kind_t                 kd;
		int                    sel;
		for (int n = 0; n < count; n++) begin
			// fresh slots now and then so stores keep replacing
			if (n % 96 == 0) begin
				for (int s = 0; s < POOL_SLOTS; s++) begin
					idx = INDEX_BITS'($urandom);
					for (int w = 0; w < POOL_WAYS; w++) begin
						key = {$urandom, $urandom};
						key[INDEX_BITS-1:0] = idx;
						key_pool[s*POOL_WAYS+w] = key;
					end
				end
			end
			key = key_pool[$urandom_range(POOL_SIZE-1)];
			idx = key[INDEX_BITS-1:0];
			near = (tt_kind[idx] == KIND_EMPTY) ? $urandom : tt_score[idx];
			sel = $urandom_range(99);
			if (sel < 10) begin
				send_item(1'($urandom_range(1)), {$urandom, $urandom},
					DEPTH_W'($urandom_range(15)), $urandom, kind_t'($urandom_range(3)),
					$urandom, $urandom);
			end else if (sel < 50) begin
				sc = ($urandom_range(7) == 0) ?
					($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000) : $urandom;
				kd = ($urandom_range(15) == 0) ? KIND_EMPTY : kind_t'($urandom_range(2));
				send_item(MODE_STORE, key, DEPTH_W'($urandom_range(15)), sc, kd,
					$urandom, $urandom);
			end else begin
				d = (tt_kind[idx] != KIND_EMPTY && $urandom_range(1)) ?
					DEPTH_W'($urandom_range(tt_depth[idx])) : DEPTH_W'($urandom_range(15));
				lo = ($urandom_range(3) == 0) ? $urandom : near + $urandom_range(6) - 3;
				hi = ($urandom_range(3) == 0) ? $urandom : near + $urandom_range(6) - 3;
				send_item(MODE_PROBE, key, d, $urandom, kind_t'($urandom_range(3)), lo, hi);
			end
		end
	endtask

	initial begin
		reset_dut();
		src_idle_pct = 10;
		sink_idle_pct = 70;
		test_empty_probe_and_ignored_store();
		test_depth_replacement();
		test_bound_windows();
		test_random_traffic(416);
		src_idle_pct = 70;
		sink_idle_pct = 10;
		test_random_traffic(416);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_traffic(418);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/ttps_pkg.sv
rtl/ttps_ram.sv
rtl/ttps_eval.sv
rtl/transposition_table_probe_store.sv
test/transposition_table_probe_store_tb.sv
